// File: hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the pair-sum search RTL
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic clocked assertion with explicit clock and reset.
`define ASSERT_ON_CLK(label, clk_sig, rst_sig, prop, msg) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) prop) \
    else $error(msg);

// Clocked assertion on the house clock and reset names.
`define ASSERT_CLK(label, prop, msg) \
  `ASSERT_ON_CLK(label, clk, rst, prop, msg)

`endif

// File: hdl/spss_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// spss_pkg
// Types and constants for the sorted pair-sum search block.
// ---------------------------------------------------------------------------
package spss_pkg;

  localparam int VALUE_BITS        = 16;
  localparam int SUM_BITS          = VALUE_BITS + 1;
  localparam int DEF_STORE_DEPTH   = 64;

  typedef logic [VALUE_BITS-1:0] value_t;
  typedef logic [SUM_BITS-1:0]   sum_t;

  typedef struct packed {
    value_t value;
    logic   last;
  } item_t;

  typedef struct packed {
    logic found;
    logic overflow;
  } result_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PRIME,
    ST_SEARCH
  } state_t;

  // status from the pointer datapath to the sequencer
  typedef struct packed {
    logic exhausted;
    logic hit;
  } stat_t;

  // controls from the sequencer to the pointer datapath
  typedef struct packed {
    logic busy;
    logic prime;
    logic search;
    logic finish;
  } ctl_t;

endpackage

// File: hdl/sorted_pair_sum_search.sv
`timescale 1ns / 1ps
// Loads one item per cycle while idle; an item marked last starts the search.
// After last, the sequencer primes the reads, then takes N pointer steps (at most count - 1),
// so at most STORE_DEPTH - 1 steps; one pointer step per cycle from the dual-read RAM.
// busy stays high from the cycle after last until the done strobe; results cannot stall.
// Synchronous active-high reset clears control, list count, overflow flag and target_sum.
// ---------------------------------------------------------------------------
// sorted_pair_sum_search
// Two-pointer pair-sum search over a list held in on-chip RAM.
// ---------------------------------------------------------------------------
module sorted_pair_sum_search #(
  parameter int STORE_DEPTH = spss_pkg::DEF_STORE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  spss_pkg::item_t   item,
  output logic              done,
  output spss_pkg::result_t result,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  spss_pkg::sum_t    cfg_data
);

  import spss_pkg::*;

  `include "assert_macros.svh"

  localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int CW = $clog2(STORE_DEPTH + 1);

  ctl_t            ctl;
  stat_t           stat;
  sum_t            target_sum;
  logic [CW-1:0]   cnt;
  logic            ovf;
  logic            accept;
  logic            room;
  logic [AW-1:0]   lo;
  logic [AW-1:0]   hi;
  logic [AW-1:0]   lo_next;
  logic [AW-1:0]   hi_next;
  value_t          rdata_a;
  value_t          rdata_b;
  sum_t            sum;

  assign busy      = ctl.busy;
  assign cfg_ready = !ctl.busy;
  assign accept    = start && !busy;
  assign room      = cnt < CW'(STORE_DEPTH);

  spss_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .accept_last (accept && item.last),
    .stat        (stat),
    .ctl         (ctl)
  );

  spss_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk     (clk),
    .we      (accept && room),
    .waddr   (cnt[AW-1:0]),
    .wdata   (item.value),
    .raddr_a (lo_next),
    .rdata_a (rdata_a),
    .raddr_b (hi_next),
    .rdata_b (rdata_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      target_sum <= '0;
    end else if (cfg_valid && cfg_ready) begin
      target_sum <= cfg_data;
    end
  end

  // list fill count and truncation flag; cleared when the search reports
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      ovf <= 1'b0;
    end else if (ctl.finish) begin
      cnt <= '0;
      ovf <= 1'b0;
    end else if (accept) begin
      if (room) begin
        cnt <= cnt + CW'(1);
      end else begin
        ovf <= 1'b1;
      end
    end
  end

  // read data belongs to the current lo/hi pair
  assign sum            = {1'b0, rdata_a} + {1'b0, rdata_b};
  assign stat.exhausted = !(lo < hi);
  assign stat.hit       = (sum == target_sum);

  // drive read addresses from next pointers so the registered read data lines up with lo/hi
  always_comb begin
    lo_next = lo;
    hi_next = hi;
    priority if (ctl.prime) begin
      lo_next = '0;
      hi_next = AW'(cnt - CW'(1));
    end else if (ctl.search && !ctl.finish) begin
      if (sum < target_sum) begin
        lo_next = lo + AW'(1);
      end else begin
        hi_next = hi - AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    lo <= lo_next;
    hi <= hi_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.finish) begin
      result.found    <= !stat.exhausted && stat.hit;
      result.overflow <= ovf;
    end
  end

  `ASSERT_CLK(a_done_clears, done |-> (cnt == '0) && !ovf, "list state not cleared at result")
  `ASSERT_CLK(a_ptr_order, ctl.search |-> lo <= hi, "left pointer passed right pointer")

endmodule

// File: hdl/spss_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// spss_ram
// Generic RAM: one write port, two read ports, registered read data.
// ---------------------------------------------------------------------------
module spss_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// File: hdl/spss_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// spss_ctrl
// Sequencer: idle/load, prime the memory reads, then step the search.
// ---------------------------------------------------------------------------
module spss_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            accept_last,
  input  spss_pkg::stat_t stat,
  output spss_pkg::ctl_t  ctl
);

  import spss_pkg::*;

  `include "assert_macros.svh"

  state_t state;
  state_t state_next;
  logic   finish;

  assign finish = (state == ST_SEARCH) && (stat.exhausted || stat.hit);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept_last) begin
          state_next = ST_PRIME;
        end
      end
      ST_PRIME: begin
        state_next = ST_SEARCH;
      end
      ST_SEARCH: begin
        if (finish) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    ctl = '0;
    unique case (state)
      ST_IDLE: begin
        ctl.busy = 1'b0;
      end
      ST_PRIME: begin
        ctl.busy  = 1'b1;
        ctl.prime = 1'b1;
      end
      ST_SEARCH: begin
        ctl.busy   = 1'b1;
        ctl.search = 1'b1;
        ctl.finish = finish;
      end
      default: begin
        ctl = '0;
      end
    endcase
  end

  `ASSERT_CLK(a_last_primes, accept_last && !ctl.busy |=> ctl.prime, "last item did not start search")
  `ASSERT_CLK(a_step_stays, ctl.search && !ctl.finish |=> ctl.search, "search left early")

endmodule
